FILE: hdl/qmml_pkg.sv
`timescale 1ns / 1ps

package qmml_pkg;

  // field widths
  localparam int THR_W  = 11;  // throttle-type values, unsigned
  localparam int CORR_W = 14;  // controller corrections, two's complement
  localparam int SUM_W  = 18;  // mixer arithmetic, signed, cannot overflow

  localparam int NUM_MOTORS = 4;
  localparam int NUM_AXES   = 3;  // roll, pitch, yaw

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_X           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_REVERSE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THROTTLE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THROTTLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COMMAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_LOW_LEVEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_LOW_STICK = 3'd6;

  localparam logic [THR_W-1:0] RST_MIN_THROTTLE    = 11'd1150;
  localparam logic [THR_W-1:0] RST_MAX_THROTTLE    = 11'd1850;
  localparam logic [THR_W-1:0] RST_STOP_COMMAND    = 11'd1000;
  localparam logic [THR_W-1:0] RST_STICK_LOW_LEVEL = 11'd1100;

  typedef struct packed {
    logic             frame_x;
    logic             yaw_reverse;
    logic [THR_W-1:0] min_throttle;
    logic [THR_W-1:0] max_throttle;
    logic [THR_W-1:0] stop_command;
    logic [THR_W-1:0] stick_low_level;
    logic             stop_on_low_stick;
  } qmml_cfg_t;

  typedef struct packed {
    logic [THR_W-1:0]         throttle_command;
    logic signed [CORR_W-1:0] roll_correction;
    logic signed [CORR_W-1:0] pitch_correction;
    logic signed [CORR_W-1:0] yaw_correction;
    logic [THR_W-1:0]         raw_throttle;
    logic                     armed;
    logic                     altitude_hold;
  } qmml_item_t;

  typedef logic [NUM_MOTORS-1:0][THR_W-1:0] motor_vec_t;

  // per-axis weight of a correction on one motor
  typedef logic [1:0] mix_sign_t;
  localparam mix_sign_t SGN_ZERO = 2'd0;
  localparam mix_sign_t SGN_POS  = 2'd1;
  localparam mix_sign_t SGN_NEG  = 2'd2;

  // rows: rear, right, left, front; columns: roll, pitch, yaw
  localparam mix_sign_t MIX_PLUS [NUM_MOTORS][NUM_AXES] = '{
    '{SGN_ZERO, SGN_POS,  SGN_NEG},
    '{SGN_NEG,  SGN_ZERO, SGN_POS},
    '{SGN_POS,  SGN_ZERO, SGN_POS},
    '{SGN_ZERO, SGN_NEG,  SGN_NEG}
  };

  // rows: rear right, front right, rear left, front left
  localparam mix_sign_t MIX_X [NUM_MOTORS][NUM_AXES] = '{
    '{SGN_NEG, SGN_POS, SGN_NEG},
    '{SGN_NEG, SGN_NEG, SGN_POS},
    '{SGN_POS, SGN_POS, SGN_POS},
    '{SGN_POS, SGN_NEG, SGN_NEG}
  };

  function automatic logic signed [SUM_W-1:0] apply_sign(
    input logic signed [SUM_W-1:0] v,
    input mix_sign_t               s
  );
    logic signed [SUM_W-1:0] res;
    case (s)
      SGN_POS: res = v;
      SGN_NEG: res = -v;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/qmml_ifs.sv
`timescale 1ns / 1ps

interface qmml_in_if import qmml_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [THR_W-1:0]         throttle_command;
  logic signed [CORR_W-1:0] roll_correction;
  logic signed [CORR_W-1:0] pitch_correction;
  logic signed [CORR_W-1:0] yaw_correction;
  logic [THR_W-1:0]         raw_throttle;
  logic                     armed;
  logic                     altitude_hold;

  modport source (
    output valid, throttle_command, roll_correction, pitch_correction,
           yaw_correction, raw_throttle, armed, altitude_hold,
    input  ready
  );
  modport sink (
    input  valid, throttle_command, roll_correction, pitch_correction,
           yaw_correction, raw_throttle, armed, altitude_hold,
    output ready
  );
endinterface

interface qmml_out_if import qmml_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] motor_rear_or_rear_right;
  logic [THR_W-1:0] motor_right_or_front_right;
  logic [THR_W-1:0] motor_left_or_rear_left;
  logic [THR_W-1:0] motor_front_or_front_left;

  modport source (
    output valid, motor_rear_or_rear_right, motor_right_or_front_right,
           motor_left_or_rear_left, motor_front_or_front_left,
    input  ready
  );
  modport sink (
    input  valid, motor_rear_or_rear_right, motor_right_or_front_right,
           motor_left_or_rear_left, motor_front_or_front_left,
    output ready
  );
endinterface

interface qmml_cfg_if import qmml_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/qmml_cfg_regs.sv
`timescale 1ns / 1ps

module qmml_cfg_regs import qmml_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  qmml_cfg_if.sink   cfg_ch,
  output qmml_cfg_t  cfg
);

  qmml_cfg_t cfg_r;
  qmml_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;  // writes always taken
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FRAME_X:           cfg_nxt.frame_x           = cfg_ch.data[0];
        REG_YAW_REVERSE:       cfg_nxt.yaw_reverse       = cfg_ch.data[0];
        REG_MIN_THROTTLE:      cfg_nxt.min_throttle      = cfg_ch.data;
        REG_MAX_THROTTLE:      cfg_nxt.max_throttle      = cfg_ch.data;
        REG_STOP_COMMAND:      cfg_nxt.stop_command      = cfg_ch.data;
        REG_STICK_LOW_LEVEL:   cfg_nxt.stick_low_level   = cfg_ch.data;
        REG_STOP_ON_LOW_STICK: cfg_nxt.stop_on_low_stick = cfg_ch.data[0];
        default:               cfg_nxt = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_x           <= 1'b1;
      cfg_r.yaw_reverse       <= 1'b0;
      cfg_r.min_throttle      <= RST_MIN_THROTTLE;
      cfg_r.max_throttle      <= RST_MAX_THROTTLE;
      cfg_r.stop_command      <= RST_STOP_COMMAND;
      cfg_r.stick_low_level   <= RST_STICK_LOW_LEVEL;
      cfg_r.stop_on_low_stick <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/qmml_mixer.sv
`timescale 1ns / 1ps

module qmml_mixer import qmml_pkg::*; (
  input  qmml_cfg_t  cfg,
  input  qmml_item_t item,
  output motor_vec_t motors
);

  logic signed [SUM_W-1:0] t_w;
  logic signed [SUM_W-1:0] ax_w [NUM_AXES];
  logic signed [SUM_W-1:0] m    [NUM_MOTORS];
  logic signed [SUM_W-1:0] top01;
  logic signed [SUM_W-1:0] top23;
  logic signed [SUM_W-1:0] top;
  logic signed [SUM_W-1:0] lo_w;
  logic signed [SUM_W-1:0] hi_w;
  logic signed [SUM_W-1:0] shifted [NUM_MOTORS];
  logic signed [SUM_W-1:0] clamped [NUM_MOTORS];
  logic                    over;
  logic                    low_stick;
  mix_sign_t               w;

  always_comb begin
    t_w      = $signed({{(SUM_W-THR_W){1'b0}}, item.throttle_command});
    ax_w[0]  = SUM_W'(item.roll_correction);
    ax_w[1]  = SUM_W'(item.pitch_correction);
    ax_w[2]  = cfg.yaw_reverse ? -SUM_W'(item.yaw_correction)
                               :  SUM_W'(item.yaw_correction);
    lo_w     = $signed({{(SUM_W-THR_W){1'b0}}, cfg.min_throttle});
    hi_w     = $signed({{(SUM_W-THR_W){1'b0}}, cfg.max_throttle});
    w        = SGN_ZERO;

    for (int i = 0; i < NUM_MOTORS; i++) begin
      m[i] = t_w;
      for (int j = 0; j < NUM_AXES; j++) begin
        w    = cfg.frame_x ? MIX_X[i][j] : MIX_PLUS[i][j];
        m[i] = m[i] + apply_sign(ax_w[j], w);
      end
    end

    top01 = (m[1] > m[0]) ? m[1] : m[0];
    top23 = (m[3] > m[2]) ? m[3] : m[2];
    top   = (top23 > top01) ? top23 : top01;
    over  = top > hi_w;

    low_stick = (item.raw_throttle < cfg.stick_low_level) && !item.altitude_hold;

    for (int i = 0; i < NUM_MOTORS; i++) begin
      // pull every motor down by the excess of the highest one
      shifted[i] = over ? (m[i] - top + hi_w) : m[i];
      // lower bound first, so inverted limits favour min_throttle
      if (shifted[i] < lo_w) begin
        clamped[i] = lo_w;
      end else if (shifted[i] > hi_w) begin
        clamped[i] = hi_w;
      end else begin
        clamped[i] = shifted[i];
      end

      if (!item.armed) begin
        motors[i] = cfg.stop_command;
      end else if (low_stick) begin
        motors[i] = cfg.stop_on_low_stick ? cfg.stop_command : cfg.min_throttle;
      end else begin
        motors[i] = clamped[i][THR_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/quad_motor_mixer_limiter_core.sv
`timescale 1ns / 1ps

// Quad motor mixer and limiter, plus or X frame.
//
// Channels (valid/ready, a transfer when both are high at a rising edge):
//   in_ch  - one control update: throttle, roll/pitch/yaw corrections, raw
//            stick, armed and altitude-hold flags.
//   out_ch - four motor commands, one result per update, in order.
//   cfg_ch - register writes (index, data); always ready. Write only while
//            no update is in flight.
// An update taken into the input register is mixed and limited, then loaded
//   into the result register once that is free, and is presented on out_ch.
// Throughput: one update per cycle while out_ch.ready stays high. Input register,
//   one pass of mixer/limiter logic, result register; no loops or shared units.
// Stall: while the result register is held by a stalled receiver, the
//   input register still takes one more update; in_ch.ready drops only when
//   both registers are full and out_ch.ready is low.
// Reset (rst_n low, synchronous): both stages empty, registers back to
//   X frame, no yaw reversal, 1150/1850 limits, stop 1000, stick check 1100.
module quad_motor_mixer_limiter_core import qmml_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qmml_in_if.sink   in_ch,
  qmml_out_if.source out_ch,
  qmml_cfg_if.sink  cfg_ch
);

  qmml_cfg_t  cfg;
  qmml_item_t item_r;
  qmml_item_t item_nxt;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  motor_vec_t mix_motors;
  motor_vec_t motors_r;
  motor_vec_t motors_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  logic in_xfer;
  logic s2_take;   // result register free or being emptied this cycle
  logic s1_adv;    // input stage moves to the result register

  qmml_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  qmml_mixer u_mix (
    .cfg    (cfg),
    .item   (item_r),
    .motors (mix_motors)
  );

  assign s2_take     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && s2_take;
  assign in_ch.ready = !s1_valid_r || s2_take;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    item_nxt = item_r;
    if (in_xfer) begin
      item_nxt.throttle_command = in_ch.throttle_command;
      item_nxt.roll_correction  = in_ch.roll_correction;
      item_nxt.pitch_correction = in_ch.pitch_correction;
      item_nxt.yaw_correction   = in_ch.yaw_correction;
      item_nxt.raw_throttle     = in_ch.raw_throttle;
      item_nxt.armed            = in_ch.armed;
      item_nxt.altitude_hold    = in_ch.altitude_hold;
    end

    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    motors_nxt    = s1_adv ? mix_motors : motors_r;
    out_valid_nxt = s2_take ? s1_valid_r : out_valid_r;
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    motors_r <= motors_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid                      = out_valid_r;
  assign out_ch.motor_rear_or_rear_right   = motors_r[0];
  assign out_ch.motor_right_or_front_right = motors_r[1];
  assign out_ch.motor_left_or_rear_left    = motors_r[2];
  assign out_ch.motor_front_or_front_left  = motors_r[3];

  // both stages empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // a full pipeline with a stalled receiver must refuse new updates
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("update accepted into a full pipeline");

  // an update waiting in the input stage is never dropped
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_take) |=> s1_valid_r)
    else $error("input stage lost an update");

  // a transfer into the input stage always leaves it occupied
  a_s1_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted update not registered");

  // a stage-one update always reaches the result register when it moves
  a_s2_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register missed an update");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import qmml_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RX_HOLD_AT     = 500;   // results seen before the long hold-off
  localparam int CALM_FROM      = 900;   // transfer count window with no idling
  localparam int CALM_TO        = 1150;
  localparam int MAX_REPORTS    = 10;
  localparam int TAIL_CYCLES    = 4;

  // no register lives at this index; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;

  qmml_in_if  in_if ();
  qmml_out_if out_if ();
  qmml_cfg_if cfg_if ();

  quad_motor_mixer_limiter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  qmml_cfg_t  regs_now;            // shadow of the block's registers
  qmml_item_t pending_updates[$];  // control updates not yet offered
  motor_vec_t expected_motors[$];  // motor commands owed by the block

  bit upd_taken;
  int upd_sent;
  int results_seen;
  int mismatches;
  int cycle_count;
  int rx_hold_left;
  bit rx_stall_done;
  qmml_item_t next_upd;
  qmml_item_t taken_upd;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mixer, excess shift, clamp, then low-stick and disarm overrides.
  // Plain int arithmetic, so nothing can wrap.
  function automatic motor_vec_t mix_and_limit(qmml_item_t u, qmml_cfg_t c);
    motor_vec_t res;
    int t, r, p, y, lo, hi, top, v;
    int m [NUM_MOTORS];
    t  = int'(u.throttle_command);
    r  = $signed(u.roll_correction);
    p  = $signed(u.pitch_correction);
    y  = $signed(u.yaw_correction);
    lo = int'(c.min_throttle);
    hi = int'(c.max_throttle);
    if (c.yaw_reverse) y = -y;
    if (c.frame_x) begin
      m[0] = t - r + p - y;
      m[1] = t - r - p + y;
      m[2] = t + r + p + y;
      m[3] = t + r - p - y;
    end else begin
      m[0] = t + p - y;
      m[1] = t - r + y;
      m[2] = t + r + y;
      m[3] = t - p - y;
    end
    top = m[0];
    for (int i = 1; i < NUM_MOTORS; i++) if (m[i] > top) top = m[i];
    for (int i = 0; i < NUM_MOTORS; i++) begin
      v = m[i];
      if (top > hi) v = v - (top - hi);
      // low bound checked first: with inverted limits min wins below it
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      if (u.raw_throttle < c.stick_low_level && !u.altitude_hold)
        v = c.stop_on_low_stick ? int'(c.stop_command) : lo;
      if (!u.armed) v = int'(c.stop_command);
      res[i] = v[THR_W-1:0];
    end
    return res;
  endfunction

  // idling is switched off for a stretch of transfers on each side
  function automatic bit idle_now(int n);
    return !(n >= CALM_FROM && n < CALM_TO) && ($urandom_range(99) < 13);
  endfunction

  function automatic logic signed [CORR_W-1:0] rand_corr();
    int mode, v;
    mode = $urandom_range(9);
    if (mode < 5) v = int'($urandom_range(1200)) - 600;
    else if (mode < 8) v = $urandom;
    else v = $urandom_range(1) ? -8192 : 8191;
    return v[CORR_W-1:0];
  endfunction

  function automatic qmml_item_t make_update(int t, int r, int p, int y, int raw,
                                             bit arm, bit alt);
    qmml_item_t u;
    u.throttle_command = t[THR_W-1:0];
    u.roll_correction  = r[CORR_W-1:0];
    u.pitch_correction = p[CORR_W-1:0];
    u.yaw_correction   = y[CORR_W-1:0];
    u.raw_throttle     = raw[THR_W-1:0];
    u.armed            = arm;
    u.altitude_hold    = alt;
    return u;
  endfunction

  // mostly armed with the stick above the check level, so the mixer path is
  // exercised; the rest hits the overrides
  task automatic queue_random(int n);
    qmml_item_t u;
    int lvl;
    for (int k = 0; k < n; k++) begin
      lvl = int'(regs_now.stick_low_level);
      u.throttle_command = $urandom_range(1) ? THR_W'($urandom_range(1900, 900))
                                             : THR_W'($urandom_range(2047));
      u.roll_correction  = rand_corr();
      u.pitch_correction = rand_corr();
      u.yaw_correction   = rand_corr();
      u.raw_throttle     = ($urandom_range(99) < 70) ? THR_W'($urandom_range(2047, lvl))
                                                     : THR_W'($urandom_range(2047));
      u.armed            = $urandom_range(99) < 90;
      u.altitude_hold    = 1'($urandom_range(1));
      pending_updates.push_back(u);
    end
  endtask

  task automatic queue_directed();
    int lvl;
    lvl = int'(regs_now.stick_low_level);
    pending_updates.push_back(make_update(1500, 0, 0, 0, 2047, 1, 0));
    pending_updates.push_back(make_update(2047, 8191, 8191, 8191, 2047, 1, 0));
    pending_updates.push_back(make_update(0, -8192, -8192, -8192, 2047, 1, 0));
    pending_updates.push_back(make_update(1000, 8191, -8192, 8191, 2047, 1, 1));
    pending_updates.push_back(make_update(1500, -8192, 8191, -8192, 2047, 1, 0));
    pending_updates.push_back(make_update(1800, 300, -200, 0, 2047, 1, 0));
    pending_updates.push_back(make_update(1500, 0, 0, 8191, 2047, 1, 0));
    pending_updates.push_back(make_update(1500, 0, 0, -8192, 2047, 1, 0));
    // stick just under and exactly at the check level
    pending_updates.push_back(make_update(1500, 100, 100, 100, lvl - 1, 1, 0));
    pending_updates.push_back(make_update(1500, 100, 100, 100, lvl, 1, 0));
    // altitude hold keeps the mixer running on a low stick
    pending_updates.push_back(make_update(2047, 50, -50, 25, 0, 1, 1));
    // disarmed, with and without low stick
    pending_updates.push_back(make_update(1500, 100, 100, 100, 0, 0, 0));
    pending_updates.push_back(make_update(2047, 8191, 8191, 8191, 2047, 0, 1));
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FRAME_X:           regs_now.frame_x           = val[0];
      REG_YAW_REVERSE:       regs_now.yaw_reverse       = val[0];
      REG_MIN_THROTTLE:      regs_now.min_throttle      = val[THR_W-1:0];
      REG_MAX_THROTTLE:      regs_now.max_throttle      = val[THR_W-1:0];
      REG_STOP_COMMAND:      regs_now.stop_command      = val[THR_W-1:0];
      REG_STICK_LOW_LEVEL:   regs_now.stick_low_level   = val[THR_W-1:0];
      REG_STOP_ON_LOW_STICK: regs_now.stop_on_low_stick = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // sender holds off until every owed result has arrived
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_updates.size() != 0 || in_if.valid || expected_motors.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Driver: a new update goes out at the falling edge once the previous
  // one has transferred; valid never drops while an update is waiting.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || upd_taken)) begin
      if (pending_updates.size() != 0 && !idle_now(upd_sent)) begin
        next_upd = pending_updates.pop_front();
        in_if.valid            <= 1'b1;
        in_if.throttle_command <= next_upd.throttle_command;
        in_if.roll_correction  <= next_upd.roll_correction;
        in_if.pitch_correction <= next_upd.pitch_correction;
        in_if.yaw_correction   <= next_upd.yaw_correction;
        in_if.raw_throttle     <= next_upd.raw_throttle;
        in_if.armed            <= next_upd.armed;
        in_if.altitude_hold    <= next_upd.altitude_hold;
        upd_sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // input transfer: predict the motor commands with the registers as they are
  always @(posedge clk) begin
    upd_taken = in_if.valid && in_if.ready;
    if (upd_taken) begin
      taken_upd.throttle_command = in_if.throttle_command;
      taken_upd.roll_correction  = in_if.roll_correction;
      taken_upd.pitch_correction = in_if.pitch_correction;
      taken_upd.yaw_correction   = in_if.yaw_correction;
      taken_upd.raw_throttle     = in_if.raw_throttle;
      taken_upd.armed            = in_if.armed;
      taken_upd.altitude_hold    = in_if.altitude_hold;
      expected_motors.push_back(mix_and_limit(taken_upd, regs_now));
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the block
  // fills both stages and drops in_ch.ready.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else if (!rx_stall_done && results_seen >= RX_HOLD_AT) begin
      rx_stall_done = 1'b1;
      rx_hold_left  = RX_HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !idle_now(results_seen);
    end
  end

  // Monitor: each result transfer against the oldest prediction
  always @(posedge clk) begin
    motor_vec_t got, want;
    if (out_if.valid && out_if.ready) begin
      got[0] = out_if.motor_rear_or_rear_right;
      got[1] = out_if.motor_right_or_front_right;
      got[2] = out_if.motor_left_or_rear_left;
      got[3] = out_if.motor_front_or_front_left;
      results_seen++;
      if (expected_motors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing owed: %p", results_seen, got);
      end else begin
        want = expected_motors.pop_front();
        for (int i = 0; i < NUM_MOTORS; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d motor %0d: expected %0d, got %0d",
                       results_seen, i, want[i], got[i]);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.throttle_command = '0;
    in_if.roll_correction  = '0;
    in_if.pitch_correction = '0;
    in_if.yaw_correction   = '0;
    in_if.raw_throttle     = '0;
    in_if.armed            = 1'b0;
    in_if.altitude_hold    = 1'b0;
    out_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;

    regs_now.frame_x           = 1'b1;
    regs_now.yaw_reverse       = 1'b0;
    regs_now.min_throttle      = RST_MIN_THROTTLE;
    regs_now.max_throttle      = RST_MAX_THROTTLE;
    regs_now.stop_command      = RST_STOP_COMMAND;
    regs_now.stick_low_level   = RST_STICK_LOW_LEVEL;
    regs_now.stop_on_low_stick = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values, X frame
    queue_directed();
    queue_random(200);
    wait_drained();

    // plus frame
    write_reg(REG_FRAME_X, 0);
    queue_directed();
    queue_random(200);
    wait_drained();

    // yaw reversed, stop on low stick; the long hold-off falls in here
    write_reg(REG_YAW_REVERSE, 1);
    write_reg(REG_STOP_ON_LOW_STICK, 1);
    queue_random(250);
    wait_drained();

    // widest limits, stick check disabled
    write_reg(REG_FRAME_X, 1);
    write_reg(REG_MIN_THROTTLE, 0);
    write_reg(REG_MAX_THROTTLE, 2047);
    write_reg(REG_STOP_COMMAND, 0);
    write_reg(REG_STICK_LOW_LEVEL, 0);
    write_reg(REG_STOP_ON_LOW_STICK, 0);
    queue_random(200);
    wait_drained();

    // inverted limits, every stick reading below 2047 counts as low
    write_reg(REG_MIN_THROTTLE, 2047);
    write_reg(REG_MAX_THROTTLE, 0);
    write_reg(REG_STOP_COMMAND, 2047);
    write_reg(REG_STICK_LOW_LEVEL, 2047);
    write_reg(REG_UNUSED, 5);
    queue_random(200);
    wait_drained();

    // random register sets
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_FRAME_X, $urandom_range(1));
      write_reg(REG_YAW_REVERSE, $urandom_range(1));
      write_reg(REG_MIN_THROTTLE, $urandom_range(1300, 900));
      write_reg(REG_MAX_THROTTLE, $urandom_range(2047, 1400));
      write_reg(REG_STOP_COMMAND, $urandom_range(2047));
      write_reg(REG_STICK_LOW_LEVEL, $urandom_range(2047));
      write_reg(REG_STOP_ON_LOW_STICK, $urandom_range(1));
      queue_random(120);
      wait_drained();
    end

    if (expected_motors.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
